@@ rtl/core/lefe_pkg.sv @@
`default_nettype none

package lefe_pkg;

    // Item kinds carried in the func field
    localparam logic [1:0] FUNC_FRAME = 2'd0;
    localparam logic [1:0] FUNC_COUNT = 2'd1;
    localparam logic [1:0] FUNC_EDGE  = 2'd2;

    // Byte counts of the fixed-layout items
    localparam int FRAME_BYTES = 16;
    localparam int COUNT_BYTES = 2;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    // Varint constants
    localparam logic [7:0] VARINT_PAYLOAD = 8'h7F;
    localparam logic [7:0] VARINT_CONT    = 8'h80;
    localparam logic [7:0] RESERVED_BYTE  = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIXED,
        ST_VARINT,
        ST_LEVEL
    } state_t;

    typedef enum logic [1:0] {
        SEL_FIXED,
        SEL_VARINT,
        SEL_LEVEL
    } out_sel_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] frame_time_ms;
        logic [63:0] base_position;
        logic [15:0] channel_mask;
        logic [15:0] chan_edges;
        logic [63:0] edge_position;
        logic [7:0]  edge_level;
    } item_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_frame;
        logic     load_count;
        logic     load_edge;
        logic     shift_fixed;
        logic     shift_varint;
        out_sel_t out_sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fixed_last;
        logic varint_more;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/lefe_if.sv @@
`default_nettype none

interface lefe_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] frame_time_ms;
    logic [63:0] base_position;
    logic [15:0] channel_mask;
    logic [15:0] chan_edges;
    logic [63:0] edge_position;
    logic [7:0]  edge_level;

    modport source (
        output valid, func, frame_time_ms, base_position, channel_mask,
               chan_edges, edge_position, edge_level,
        input  ready
    );
    modport sink (
        input  valid, func, frame_time_ms, base_position, channel_mask,
               chan_edges, edge_position, edge_level,
        output ready
    );
endinterface

interface lefe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last_byte;

    modport source (
        output valid, byte_out, last_byte,
        input  ready
    );
    modport sink (
        input  valid, byte_out, last_byte,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/logic_edge_frame_encoder.sv @@
// Logic-edge frame encoder.
// Input channel "item" takes one item per beat: func 0 opens a frame and
// emits a 16-byte header (type code, channel mask, reserved zero, timestamp,
// base position) and stores the base; func 1 emits a 2-byte edge count;
// func 2 emits the edge position relative to the base as an LEB128 varint
// (zero if before the base) followed by a level byte of 0 or 1. func 3 is
// accepted and dropped. Output channel "stream" carries one byte per beat,
// with last_byte set on the final byte of each item.
// One item is in work at a time; item.ready is high only when idle.
// After an item is accepted its bytes go out: 16 for a frame start, 2 for
// a count, 2 to 11 for an edge (one to ten varint bytes plus the level
// byte), none for a dropped item. The byte serializer sends one byte a cycle
// while stream.ready is high; a stall on stream.ready holds the current
// byte and the item in work. The type code is written by cfg_we/cfg_data;
// the user must write it only while idle, the block does not enforce it.
// Reset clears the type code and the frame base to zero and returns to idle.
`default_nettype none

module logic_edge_frame_encoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    lefe_item_if.sink       item,
    lefe_byte_if.source     stream
);
    import lefe_pkg::*;

    item_t   item_pl;
    cmd_t    cmd;
    status_t status;

    assign item_pl.func          = item.func;
    assign item_pl.frame_time_ms = item.frame_time_ms;
    assign item_pl.base_position = item.base_position;
    assign item_pl.channel_mask  = item.channel_mask;
    assign item_pl.chan_edges    = item.chan_edges;
    assign item_pl.edge_position = item.edge_position;
    assign item_pl.edge_level    = item.edge_level;

    lefe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_func  (item.func),
        .item_ready (item.ready),
        .out_valid  (stream.valid),
        .out_last   (stream.last_byte),
        .out_ready  (stream.ready),
        .status     (status),
        .cmd        (cmd)
    );

    lefe_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item_pl),
        .cmd      (cmd),
        .status   (status),
        .out_byte (stream.byte_out)
    );

    // No byte goes out while a new item can be taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !stream.valid)
        else $error("byte offered while idle");

    // The final byte of an item returns the block to idle
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.ready && stream.last_byte) |=> item.ready)
        else $error("not idle after last byte");

    // An edge item starts with a varint byte that is never the last one
    a_edge_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.func == FUNC_EDGE)
        |=> (stream.valid && !stream.last_byte))
        else $error("edge item did not start its varint");

    // A dropped item leaves the block idle
    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.func != FUNC_FRAME
         && item.func != FUNC_COUNT && item.func != FUNC_EDGE) |=> item.ready)
        else $error("unknown item kind not dropped");

endmodule

`default_nettype wire

@@ rtl/core/lefe_ctrl.sv @@
`default_nettype none

module lefe_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic [1:0]       item_func,
    output logic                  item_ready,
    output logic                  out_valid,
    output logic                  out_last,
    input  wire logic             out_ready,
    input  wire lefe_pkg::status_t status,
    output lefe_pkg::cmd_t        cmd
);
    import lefe_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        item_ready       = 1'b0;
        out_valid        = 1'b0;
        out_last         = 1'b0;
        cmd.load_frame   = 1'b0;
        cmd.load_count   = 1'b0;
        cmd.load_edge    = 1'b0;
        cmd.shift_fixed  = 1'b0;
        cmd.shift_varint = 1'b0;
        cmd.out_sel      = SEL_FIXED;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    // Decode the item kind; drop unknown kinds
                    unique case (item_func)
                        FUNC_FRAME:
                        begin
                            cmd.load_frame = 1'b1;
                            state_next     = ST_FIXED;
                        end
                        FUNC_COUNT:
                        begin
                            cmd.load_count = 1'b1;
                            state_next     = ST_FIXED;
                        end
                        FUNC_EDGE:
                        begin
                            cmd.load_edge = 1'b1;
                            state_next    = ST_VARINT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIXED:
            begin
                out_valid   = 1'b1;
                out_last    = status.fixed_last;
                cmd.out_sel = SEL_FIXED;
                if (out_ready)
                begin
                    cmd.shift_fixed = 1'b1;
                    if (status.fixed_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_VARINT:
            begin
                out_valid   = 1'b1;
                cmd.out_sel = SEL_VARINT;
                if (out_ready)
                begin
                    if (status.varint_more)
                    begin
                        cmd.shift_varint = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LEVEL;
                    end
                end
            end
            ST_LEVEL:
            begin
                out_valid   = 1'b1;
                out_last    = 1'b1;
                cmd.out_sel = SEL_LEVEL;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/lefe_dp.sv @@
`default_nettype none

module lefe_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [7:0]      cfg_data,
    input  wire lefe_pkg::item_t item,
    input  wire lefe_pkg::cmd_t  cmd,
    output lefe_pkg::status_t    status,
    output logic [7:0]           out_byte
);
    import lefe_pkg::*;

    logic [7:0]                   type_code_reg;
    logic [63:0]                  frame_base_reg;
    logic [FRAME_BYTES*8-1:0]     shift_reg;
    logic [FRAME_BYTES*8-1:0]     shift_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [63:0]                  rel_reg;
    logic [63:0]                  rel_next;
    logic                         level_reg;
    logic                         level_next;
    logic [64:0]                  diff;

    // Distance of the edge from the frame base; bit 64 is set when the edge lies before the base
    assign diff = {1'b0, item.edge_position} - {1'b0, frame_base_reg};

    // Control-side state: type code, frame base and byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_code_reg  <= '0;
            frame_base_reg <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                type_code_reg <= cfg_data;
            end
            if (cmd.load_frame)
            begin
                frame_base_reg <= item.base_position;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rel_reg   <= rel_next;
        level_reg <= level_next;
    end

    // Load or advance the byte sources
    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        rel_next   = rel_reg;
        level_next = level_reg;
        if (cmd.load_frame)
        begin
            shift_next = {item.base_position, item.frame_time_ms, RESERVED_BYTE,
                          item.channel_mask, type_code_reg};
            cnt_next   = CNT_W'(FRAME_BYTES);
        end
        else if (cmd.load_count)
        begin
            shift_next = {{(FRAME_BYTES*8-16){1'b0}}, item.chan_edges};
            cnt_next   = CNT_W'(COUNT_BYTES);
        end
        else if (cmd.shift_fixed)
        begin
            shift_next = {8'h00, shift_reg[FRAME_BYTES*8-1:8]};
            cnt_next   = cnt_reg - CNT_W'(1);
        end
        if (cmd.load_edge)
        begin
            rel_next   = diff[64] ? 64'd0 : diff[63:0];
            level_next = |item.edge_level;
        end
        else if (cmd.shift_varint)
        begin
            rel_next = {7'd0, rel_reg[63:7]};
        end
    end

    assign status.fixed_last  = (cnt_reg == CNT_W'(1));
    assign status.varint_more = |rel_reg[63:7];

    // Select the outgoing byte
    always_comb
    begin
        case (cmd.out_sel)
            SEL_FIXED:  out_byte = shift_reg[7:0];
            SEL_VARINT: out_byte = (rel_reg[7:0] & VARINT_PAYLOAD)
                                   | (status.varint_more ? VARINT_CONT : 8'h00);
            SEL_LEVEL:  out_byte = {7'd0, level_reg};
            default:    out_byte = shift_reg[7:0];
        endcase
    end

endmodule

`default_nettype wire

@@ tb/lefe_stream_checker.sv @@
`default_nettype none

module lefe_stream_checker
    import lefe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    lefe_item_if            item,
    lefe_byte_if            stream,
    output int              fail_count,
    output int              pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } coded_byte_t;

    // Encoder state mirrored on this side
    logic [7:0]  type_code;
    logic [63:0] frame_base;

    coded_byte_t expected_bytes[$];
    item_t       seen_item;
    coded_byte_t want;

    task automatic push_byte(input logic [7:0] b);
        coded_byte_t cb;
        cb.value = b;
        cb.last  = 1'b0;
        expected_bytes = {expected_bytes, cb};
    endtask

    // Expand one accepted item into the bytes it should produce
    task automatic encode_item(input item_t it);
        logic [63:0] rel;
        bit          emitted;
        emitted = 1'b1;
        case (it.func)
            FUNC_FRAME:
            begin
                push_byte(type_code);
                push_byte(it.channel_mask[7:0]);
                push_byte(it.channel_mask[15:8]);
                push_byte(RESERVED_BYTE);
                for (int i = 0; i < 4; i++)
                    push_byte(it.frame_time_ms[8*i +: 8]);
                for (int i = 0; i < 8; i++)
                    push_byte(it.base_position[8*i +: 8]);
                frame_base = it.base_position;
            end
            FUNC_COUNT:
            begin
                push_byte(it.chan_edges[7:0]);
                push_byte(it.chan_edges[15:8]);
            end
            FUNC_EDGE:
            begin
                // Clamp edges that fall before the frame base
                rel = (it.edge_position >= frame_base) ?
                      it.edge_position - frame_base : '0;
                while (rel >= 64'(VARINT_CONT))
                begin
                    push_byte((rel[7:0] & VARINT_PAYLOAD) | VARINT_CONT);
                    rel = rel >> 7;
                end
                push_byte(rel[7:0]);
                push_byte((it.edge_level != 8'h00) ? 8'h01 : 8'h00);
            end
            default:
                emitted = 1'b0;
        endcase
        if (emitted)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endtask

    // Track config, predict on item beats, compare on stream beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_code  = '0;
            frame_base = '0;
            fail_count = 0;
            pending    = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_we)
                type_code = cfg_data;
            if (item.valid && item.ready)
            begin
                seen_item.func          = item.func;
                seen_item.frame_time_ms = item.frame_time_ms;
                seen_item.base_position = item.base_position;
                seen_item.channel_mask  = item.channel_mask;
                seen_item.chan_edges    = item.chan_edges;
                seen_item.edge_position = item.edge_position;
                seen_item.edge_level    = item.edge_level;
                encode_item(seen_item);
            end
            if (stream.valid && stream.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("byte_out: expected none, got %02h", stream.byte_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (stream.byte_out !== want.value)
                    begin
                        $error("byte_out: expected %02h, got %02h",
                               want.value, stream.byte_out);
                        fail_count++;
                    end
                    if (stream.last_byte !== want.last)
                    begin
                        $error("last_byte: expected %0b, got %0b",
                               want.last, stream.last_byte);
                        fail_count++;
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_logic_edge_frame_encoder.sv @@
`default_nettype none

module tb_logic_edge_frame_encoder;
    import lefe_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int ITEMS_PER_PHASE = 84;
    localparam int NUM_PHASES      = 4;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    int items_sent;
    bit calm;

    lefe_item_if item_ch();
    lefe_byte_if byte_ch();

    logic_edge_frame_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .stream   (byte_ch)
    );

    lefe_stream_checker stream_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item       (item_ch),
        .stream     (byte_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("logic_edge_frame_encoder: mismatch");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.func          = 2'($urandom_range(0, 3));
        it.frame_time_ms = $urandom();
        it.base_position = rand64();
        it.channel_mask  = 16'($urandom());
        it.chan_edges    = 16'($urandom());
        it.edge_position = rand64();
        it.edge_level    = 8'($urandom());
        return it;
    endfunction

    // Pick an edge position that spreads the varint over all its lengths
    function automatic logic [63:0] pick_position(input logic [63:0] base);
        int k;
        case ($urandom_range(0, 5))
            0: pick_position = base - 64'($urandom_range(1, 300));
            1: pick_position = base;
            2: pick_position = base + (rand64() >> $urandom_range(0, 63));
            3: pick_position = rand64();
            4:
            begin
                k = $urandom_range(1, 9);
                pick_position = base + ((64'd1 << (7 * k)) - 64'($urandom_range(0, 1)));
            end
            default: pick_position = '1;
        endcase
    endfunction

    // Present one item, hold it until taken, then idle a drawn number of cycles
    task automatic send_item(input item_t it);
        int gap;
        item_ch.func          <= it.func;
        item_ch.frame_time_ms <= it.frame_time_ms;
        item_ch.base_position <= it.base_position;
        item_ch.channel_mask  <= it.channel_mask;
        item_ch.chan_edges    <= it.chan_edges;
        item_ch.edge_position <= it.edge_position;
        item_ch.edge_level    <= it.edge_level;
        item_ch.valid         <= 1'b1;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (it.func inside {FUNC_FRAME, FUNC_COUNT, FUNC_EDGE})
            items_sent++;
        @(negedge clk);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic hold_items_off();
        item_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_type_code(input logic [7:0] code);
        cfg_we   <= 1'b1;
        cfg_data <= code;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // A frame start, then channels each with a count and its edges
    task automatic send_random_frame();
        item_t hdr;
        item_t cnt;
        item_t ev;
        int    nch;
        int    nev;
        hdr      = rand_item();
        hdr.func = FUNC_FRAME;
        case ($urandom_range(0, 3))
            0: hdr.base_position = rand64();
            1: hdr.base_position = rand64() >> $urandom_range(1, 63);
            2: hdr.base_position = '0;
            default: hdr.base_position = '1;
        endcase
        send_item(hdr);
        nch = $urandom_range(0, 4);
        for (int c = 0; c < nch; c++)
        begin
            nev      = $urandom_range(0, 5);
            cnt      = rand_item();
            cnt.func = FUNC_COUNT;
            if ($urandom_range(0, 7) != 0)
                cnt.chan_edges = 16'(nev);
            send_item(cnt);
            for (int e = 0; e < nev; e++)
            begin
                ev               = rand_item();
                ev.func          = FUNC_EDGE;
                ev.edge_position = pick_position(hdr.base_position);
                if ($urandom_range(0, 2) != 0)
                    ev.edge_level = 8'($urandom_range(0, 1));
                send_item(ev);
            end
        end
    endtask

    task automatic send_directed();
        item_t d;
        // Edges and counts before any frame start use base zero
        d = '0; d.func = FUNC_EDGE; d.edge_position = '0; d.edge_level = 8'h00;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = '1; d.edge_level = 8'hFF;
        send_item(d);
        d = '0; d.func = FUNC_COUNT; d.chan_edges = 16'h0000;
        send_item(d);
        d = '0; d.func = FUNC_COUNT; d.chan_edges = 16'hFFFF;
        send_item(d);
        // Frame with every field at its top
        d = '1; d.func = FUNC_FRAME;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = '1; d.edge_level = 8'h01;
        send_item(d);
        // Edge before the base clamps to zero
        d = '0; d.func = FUNC_EDGE; d.edge_position = '0; d.edge_level = 8'h80;
        send_item(d);
        // Ignored item kind
        d = rand_item(); d.func = 2'd3;
        send_item(d);
        d = '0; d.func = FUNC_FRAME;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = 64'd127; d.edge_level = 8'h7F;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = 64'd128; d.edge_level = 8'h00;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = 64'd16383; d.edge_level = 8'h02;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = 64'd16384; d.edge_level = 8'h01;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = '1; d.edge_level = 8'h00;
        send_item(d);
        d = '0; d.func = FUNC_FRAME; d.frame_time_ms = 32'h1234_5678;
        d.base_position = 64'd1000; d.channel_mask = 16'hA5A5;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = 64'd999; d.edge_level = 8'h01;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = 64'd1000; d.edge_level = 8'h55;
        send_item(d);
        d = '0; d.func = FUNC_EDGE; d.edge_position = 64'd1000 + (64'd1 << 63);
        d.edge_level = 8'hAA;
        send_item(d);
        d = '0; d.func = FUNC_COUNT; d.chan_edges = 16'h8001;
        send_item(d);
        d = rand_item(); d.func = 2'd3;
        send_item(d);
    endtask

    // Output side: stall a drawn number of cycles before each byte
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                byte_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            byte_ch.ready <= 1'b1;
            @(posedge clk);
            while (!byte_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [7:0] phase_codes[NUM_PHASES];
        int         target;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_data              <= '0;
        item_ch.valid         <= 1'b0;
        item_ch.func          <= '0;
        item_ch.frame_time_ms <= '0;
        item_ch.base_position <= '0;
        item_ch.channel_mask  <= '0;
        item_ch.chan_edges    <= '0;
        item_ch.edge_position <= '0;
        item_ch.edge_level    <= '0;
        byte_ch.ready         <= 1'b0;
        cycle_count = 0;
        items_sent  = 0;
        calm        = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items run with the type code at its reset value
        send_directed();
        hold_items_off();
        drain();

        phase_codes[0] = 8'hFF;
        phase_codes[1] = 8'h00;
        phase_codes[2] = 8'($urandom());
        phase_codes[3] = 8'($urandom());
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_type_code(phase_codes[p]);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(rand_item());
                else
                    send_random_frame();
            end
            hold_items_off();
            drain();
        end

        if (fail_count == 0)
            $display("logic_edge_frame_encoder: match");
        else
            $display("logic_edge_frame_encoder: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
